### hw/rtl/sth_pkg.sv
// Shared constants, codes and types for the slot table with unique handles.
package sth_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 2);
  localparam int HANDLE_W   = 16;
  localparam int KIND_W     = 8;
  localparam int LIMIT_W    = 7;

  localparam logic [2:0] MODE_SPAWN   = 3'd0;
  localparam logic [2:0] MODE_FREE    = 3'd1;
  localparam logic [2:0] MODE_MARK    = 3'd2;
  localparam logic [2:0] MODE_FIND    = 3'd3;
  localparam logic [2:0] MODE_INSPECT = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_KIND  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_HANDLE = 3'd3;
  localparam logic [2:0] ST_SLOT_FREE = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic                marked;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
  } slot_word_t;

  localparam int WORD_W = $bits(slot_word_t);

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    slot_word_t        hit_word;
    logic [SLOT_W-1:0] free_idx;
  } scan_res_t;

endpackage

### hw/rtl/sth_ram.sv
// Generic simple dual-port RAM with registered read.
module sth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sth_scan.sv
// Shared scan unit: walks the slot memory one entry a cycle comparing handles.
module sth_scan
  import sth_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  stop_on_hit,
  input  logic [HANDLE_W-1:0]   target,
  input  logic [SLOT_COUNT-1:0] live,
  input  slot_word_t            rd_word,
  output logic [SLOT_W-1:0]     rd_addr,
  output logic                  busy,
  output scan_res_t             res
);

  logic [CNT_W-1:0]  cnt;
  logic              p_vld;
  logic [SLOT_W-1:0] p_idx;
  logic              free_found;
  logic              match;
  logic              last;
  logic              finish;

  assign rd_addr = cnt[SLOT_W-1:0];
  assign match   = p_vld && live[p_idx] && (rd_word.handle == target);
  assign last    = p_vld && (p_idx == SLOT_W'(SLOT_COUNT - 1));
  assign finish  = (match && stop_on_hit) || last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      p_vld    <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= busy && finish;
      if (start) begin
        busy       <= 1'b1;
        cnt        <= '0;
        p_vld      <= 1'b0;
        res.hit    <= 1'b0;
        free_found <= 1'b0;
      end else if (busy) begin
        p_vld <= !finish && (cnt < CNT_W'(SLOT_COUNT));
        if (cnt < CNT_W'(SLOT_COUNT)) begin
          p_idx <= cnt[SLOT_W-1:0];
          cnt   <= cnt + 1'b1;
        end
        if (match && !res.hit) begin
          res.hit      <= 1'b1;
          res.hit_idx  <= p_idx;
          res.hit_word <= rd_word;
        end
        if (p_vld && !live[p_idx] && !free_found) begin
          free_found   <= 1'b1;
          res.free_idx <= p_idx;
        end
        if (finish) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/slot_table_with_unique_handles_top.sv
// Top level: slot table sequencer, live bits, slot memory and scan unit.
//
//  channel | direction | fields
//  s_*     | in        | tuser: mode; tdata: entry_kind, slot_index, query_handle
//  m_*     | out       | tuser: ok, status; tdata: slot, handle, kind, marked, live_count
//  cfg_*   | in        | data: slot_limit
//
// Free and refused ops pass IDLE, DISPATCH and PUT; mark and inspect add a READ state.
// Find: the scan unit walks the slot memory one entry a cycle and stops at the first hit.
// Spawn: each handle issue try is a full scan of the slot memory, up to SLOT_COUNT+1 tries.
// Reset clears the live bits; no memory clearing pass. One item at a time;
// a new beat is taken while the previous result waits on m_tready.
module slot_table_with_unique_handles_top
  import sth_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // entry_kind[7:0], slot_index[13:8], query_handle[29:14]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_slot[5:0], result_handle[21:6], result_kind[29:22],
                                 // result_marked[30], live_count[37:31]
  output logic [3:0]  m_tuser,   // ok[0], status[3:1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // slot_limit[6:0]
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_ISSUE    = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_FIND     = 3'd4;
  localparam logic [2:0] S_READ     = 3'd5;
  localparam logic [2:0] S_PUT      = 3'd6;

  logic [2:0]            state;
  logic [LIMIT_W-1:0]    slot_limit;
  logic [LIMIT_W-1:0]    lim;
  logic [LIMIT_W-1:0]    live_total;
  logic [HANDLE_W-1:0]   next_handle;
  logic [HANDLE_W-1:0]   nh_inc;
  logic [HANDLE_W-1:0]   cur_h;
  logic [CNT_W-1:0]      tries;
  logic [SLOT_COUNT-1:0] slot_live;

  logic [2:0]            op_mode;
  logic [KIND_W-1:0]     op_kind;
  logic [SLOT_W-1:0]     op_idx;
  logic [HANDLE_W-1:0]   op_query;

  logic                  r_ok;
  logic [2:0]            r_status;
  logic [SLOT_W-1:0]     r_slot;
  slot_word_t            r_word;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  slot_word_t            ram_wdata;
  logic [SLOT_W-1:0]     ram_raddr;
  slot_word_t            ram_rdata;

  logic                  scan_start;
  logic                  scan_busy;
  logic [SLOT_W-1:0]     scan_addr;
  logic [HANDLE_W-1:0]   scan_target;
  scan_res_t             scan_res;

  logic                  in_beat;
  logic                  out_free;
  logic                  cur_live;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cur_live  = slot_live[op_idx];
  assign lim       = (slot_limit < LIMIT_W'(SLOT_COUNT)) ? slot_limit : LIMIT_W'(SLOT_COUNT);
  assign nh_inc    = (next_handle + 1'b1 == '0) ? HANDLE_W'(1) : next_handle + 1'b1;

  assign scan_start  = (state == S_ISSUE) ||
                       (state == S_DISPATCH && op_mode == MODE_FIND && op_query != '0);
  assign scan_target = (op_mode == MODE_FIND) ? op_query : cur_h;
  assign ram_raddr   = scan_busy ? scan_addr : op_idx;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op_idx;
    ram_wdata = ram_rdata;
    if (state == S_SCAN && scan_res.done && !scan_res.hit) begin
      ram_we           = 1'b1;
      ram_waddr        = scan_res.free_idx;
      ram_wdata.marked = 1'b0;
      ram_wdata.kind   = op_kind;
      ram_wdata.handle = cur_h;
    end else if (state == S_READ && op_mode == MODE_MARK) begin
      ram_we           = 1'b1;
      ram_wdata.marked = 1'b1;
    end
  end

  sth_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sth_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .stop_on_hit (op_mode == MODE_FIND),
    .target      (scan_target),
    .live        (slot_live),
    .rd_word     (ram_rdata),
    .rd_addr     (scan_addr),
    .busy        (scan_busy),
    .res         (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_limit  <= LIMIT_W'(64);
      live_total  <= '0;
      next_handle <= HANDLE_W'(1);
      slot_live   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slot_limit <= cfg_data;
      end
      if (m_tvalid && m_tready && state != S_PUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            op_mode  <= s_tuser;
            op_kind  <= s_tdata[7:0];
            op_idx   <= s_tdata[13:8];
            op_query <= s_tdata[29:14];
            state    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          r_word <= '0;
          unique case (op_mode)
            MODE_SPAWN: begin
              r_ok   <= 1'b0;
              r_slot <= '0;
              if (op_kind == '0) begin
                r_status <= ST_BAD_KIND;
                state    <= S_PUT;
              end else if (live_total >= lim) begin
                r_status <= ST_FULL;
                state    <= S_PUT;
              end else begin
                tries <= '0;
                state <= S_ISSUE;
              end
            end
            MODE_FREE: begin
              r_slot <= op_idx;
              state  <= S_PUT;
              if (cur_live) begin
                slot_live[op_idx] <= 1'b0;
                live_total        <= live_total - 1'b1;
                r_ok              <= 1'b1;
                r_status          <= ST_OK;
              end else begin
                r_ok     <= 1'b0;
                r_status <= ST_SLOT_FREE;
              end
            end
            MODE_MARK, MODE_INSPECT: begin
              r_slot <= op_idx;
              if (cur_live) begin
                state <= S_READ;
              end else begin
                r_ok     <= 1'b0;
                r_status <= ST_SLOT_FREE;
                state    <= S_PUT;
              end
            end
            MODE_FIND: begin
              r_ok     <= 1'b0;
              r_slot   <= '0;
              r_status <= ST_NOT_FOUND;
              state    <= (op_query != '0) ? S_FIND : S_PUT;
            end
            default: begin
              r_ok     <= 1'b0;
              r_slot   <= '0;
              r_status <= ST_NOT_FOUND;
              state    <= S_PUT;
            end
          endcase
        end
        S_ISSUE: begin
          cur_h       <= next_handle;
          next_handle <= nh_inc;
          tries       <= tries + 1'b1;
          state       <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (!scan_res.hit) begin
              slot_live[scan_res.free_idx] <= 1'b1;
              live_total    <= live_total + 1'b1;
              r_ok          <= 1'b1;
              r_status      <= ST_OK;
              r_slot        <= scan_res.free_idx;
              r_word.marked <= 1'b0;
              r_word.kind   <= op_kind;
              r_word.handle <= cur_h;
              state         <= S_PUT;
            end else if (tries == CNT_W'(SLOT_COUNT + 1)) begin
              r_status <= ST_NO_HANDLE;
              state    <= S_PUT;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_FIND: begin
          if (scan_res.done) begin
            if (scan_res.hit) begin
              r_ok     <= 1'b1;
              r_status <= ST_OK;
              r_slot   <= scan_res.hit_idx;
              r_word   <= scan_res.hit_word;
            end
            state <= S_PUT;
          end
        end
        S_READ: begin
          r_ok     <= 1'b1;
          r_status <= ST_OK;
          r_word   <= ram_wdata;
          state    <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {r_status, r_ok};
            m_tdata  <= {2'b00, live_total, r_word.marked, r_word.kind, r_word.handle, r_slot};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for the slot table: directed table, then random phases against a predictor.
module tb;
  import sth_pkg::*;

  localparam logic [2:0] MODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES     = 100;

  typedef struct packed {
    logic [2:0]          mode;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   idx;
    logic [HANDLE_W-1:0] query;
  } op_t;

  typedef struct packed {
    logic                ok;
    logic [2:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
    logic                marked;
    logic [6:0]          live;
  } res_t;

  typedef struct packed {
    op_t  op;
    logic typed;
    res_t want;
  } dir_row_t;

  typedef struct {
    int items;
    int lim;
    int tx;
    int rx;
    int spawn;
    int frees;
    bit hold;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  slot_table_with_unique_handles_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // table model
  logic [KIND_W-1:0]   tbl_kind   [SLOT_COUNT];
  logic [HANDLE_W-1:0] tbl_handle [SLOT_COUNT];
  logic                tbl_mark   [SLOT_COUNT];
  int                  live_n;
  logic [HANDLE_W-1:0] handle_ctr;
  int                  limit_reg;

  res_t pending_results [$];
  int   mismatch_cnt = 0;
  int   quiet_cycles = 0;
  bit   stuck = 0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  bit   rx_hold_req = 0;
  logic now_typed = 1'b0;
  res_t now_want = '0;

  function automatic res_t slot_view(res_t r, int s);
    r.ok     = 1'b1;
    r.status = ST_OK;
    r.slot   = SLOT_W'(s);
    r.handle = tbl_handle[s];
    r.kind   = tbl_kind[s];
    r.marked = tbl_mark[s];
    return r;
  endfunction

  function automatic logic handle_in_use(logic [HANDLE_W-1:0] h);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (tbl_kind[i] != 0 && tbl_handle[i] == h) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t table_apply(op_t o);
    res_t                r;
    int                  lim;
    int                  slot;
    int                  tries;
    logic [HANDLE_W-1:0] h;
    logic [HANDLE_W-1:0] cand;
    r = '0;
    lim = (limit_reg < SLOT_COUNT) ? limit_reg : SLOT_COUNT;
    case (o.mode)
      MODE_SPAWN: begin
        slot = SLOT_COUNT;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
          if (tbl_kind[i] == 0) slot = i;
        if (o.kind == 0) begin
          r.status = ST_BAD_KIND;
        end else if (live_n >= lim || slot >= SLOT_COUNT) begin
          r.status = ST_FULL;
        end else begin
          h = '0;
          tries = 0;
          while (h == 0 && tries <= SLOT_COUNT) begin
            cand = handle_ctr;
            handle_ctr = handle_ctr + 1'b1;
            if (handle_ctr == 0) handle_ctr = 1;
            if (!handle_in_use(cand)) h = cand;
            tries++;
          end
          if (h == 0) begin
            r.status = ST_NO_HANDLE;
          end else begin
            tbl_kind[slot]   = o.kind;
            tbl_handle[slot] = h;
            tbl_mark[slot]   = 1'b0;
            live_n++;
            r = slot_view(r, slot);
          end
        end
      end
      MODE_FREE, MODE_MARK, MODE_INSPECT: begin
        r.slot = o.idx;
        if (tbl_kind[o.idx] == 0) begin
          r.status = ST_SLOT_FREE;
        end else begin
          if (o.mode == MODE_FREE) begin
            tbl_kind[o.idx]   = '0;
            tbl_handle[o.idx] = '0;
            tbl_mark[o.idx]   = 1'b0;
            live_n--;
          end else if (o.mode == MODE_MARK) begin
            tbl_mark[o.idx] = 1'b1;
          end
          r = slot_view(r, o.idx);
        end
      end
      MODE_FIND: begin
        slot = SLOT_COUNT;
        if (o.query != 0)
          for (int i = SLOT_COUNT - 1; i >= 0; i--)
            if (tbl_kind[i] != 0 && tbl_handle[i] == o.query) slot = i;
        if (slot >= SLOT_COUNT) r.status = ST_NOT_FOUND;
        else r = slot_view(r, slot);
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    r.live = 7'(live_n);
    return r;
  endfunction

  function automatic op_t gen_op(int spawn_pct, int free_pct);
    op_t o;
    int  r;
    int  pick;
    int  live_q [$];
    o.kind  = KIND_W'($urandom);
    o.idx   = SLOT_W'($urandom);
    o.query = HANDLE_W'($urandom);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (tbl_kind[i] != 0) live_q.push_back(i);
    pick = (live_q.size() > 0) ? live_q[$urandom_range(live_q.size() - 1)] : -1;
    r = $urandom_range(99);
    if (r < spawn_pct) begin
      o.mode = MODE_SPAWN;
      o.kind = ($urandom_range(99) < 6) ? '0 : KIND_W'($urandom_range(255, 1));
    end else begin
      if (r < spawn_pct + free_pct) begin
        o.mode = MODE_FREE;
      end else begin
        r = $urandom_range(99);
        if (r < 25) o.mode = MODE_MARK;
        else if (r < 60) o.mode = MODE_FIND;
        else if (r < 92) o.mode = MODE_INSPECT;
        else o.mode = 3'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
      end
      if (pick >= 0 && $urandom_range(99) < 75) o.idx = SLOT_W'(pick);
      if (o.mode == MODE_FIND) begin
        r = $urandom_range(99);
        if (r < 10) o.query = '0;
        else if (r < 75 && pick >= 0) o.query = tbl_handle[pick];
      end
    end
    return o;
  endfunction

  task automatic push_op(op_t o, logic typed, res_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= {2'b00, o.query, o.idx, o.kind};
    s_tuser   <= o.mode;
    now_typed <= typed;
    now_want  <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // beat monitor, scoreboard and watchdog
  always @(posedge clk) begin : mon
    op_t  acc_op;
    res_t want;
    res_t got;
    bit   moved;
    if (!rst) begin
      moved = 0;
      if (s_tvalid && s_tready) begin
        acc_op = '{s_tuser, s_tdata[7:0], s_tdata[13:8], s_tdata[29:14]};
        want = table_apply(acc_op);
        pending_results.push_back(now_typed ? now_want : want);
        moved = 1;
      end
      if (cfg_valid && cfg_ready) begin
        limit_reg = cfg_data;
        moved = 1;
      end
      if (m_tvalid && m_tready) begin
        moved = 1;
        got = '{m_tuser[0], m_tuser[3:1], m_tdata[5:0], m_tdata[21:6], m_tdata[29:22],
                m_tdata[30], m_tdata[37:31]};
        if (pending_results.size() == 0) begin
          if (mismatch_cnt < 10) $display("tb: unexpected result beat %h", got);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.ok !== want.ok || got.status !== want.status || got.slot !== want.slot ||
              got.handle !== want.handle || got.kind !== want.kind ||
              got.marked !== want.marked || got.live !== want.live) begin
            if (mismatch_cnt < 10)
              $display("tb: mismatch want ok=%0d st=%0d slot=%0d h=%0d k=%0d m=%0d live=%0d",
                       want.ok, want.status, want.slot, want.handle, want.kind,
                       want.marked, want.live,
                       " | got ok=%0d st=%0d slot=%0d h=%0d k=%0d m=%0d live=%0d",
                       got.ok, got.status, got.slot, got.handle, got.kind,
                       got.marked, got.live);
            mismatch_cnt++;
          end
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) stuck = 1;
    end
  end

  initial begin
    wait (stuck);
    $display("tb: FAIL");
    $finish;
  end

  dir_row_t dir_tab [21] = '{
    '{'{MODE_INSPECT, 8'd0, 6'd0, 16'd0}, 1'b1,
      '{1'b0, ST_SLOT_FREE, 6'd0, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_INSPECT, 8'd0, 6'd63, 16'd0}, 1'b1,
      '{1'b0, ST_SLOT_FREE, 6'd63, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_FREE, 8'd255, 6'd5, 16'd0}, 1'b1,
      '{1'b0, ST_SLOT_FREE, 6'd5, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_MARK, 8'd0, 6'd63, 16'd65535}, 1'b1,
      '{1'b0, ST_SLOT_FREE, 6'd63, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_FIND, 8'd0, 6'd0, 16'd0}, 1'b1,
      '{1'b0, ST_NOT_FOUND, 6'd0, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_FIND, 8'd255, 6'd63, 16'd65535}, 1'b1,
      '{1'b0, ST_NOT_FOUND, 6'd0, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_BAD_LO, 8'd1, 6'd3, 16'd1}, 1'b1,
      '{1'b0, ST_NOT_FOUND, 6'd0, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_BAD_HI, 8'd255, 6'd63, 16'd65535}, 1'b1,
      '{1'b0, ST_NOT_FOUND, 6'd0, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_SPAWN, 8'd0, 6'd63, 16'd65535}, 1'b1,
      '{1'b0, ST_BAD_KIND, 6'd0, 16'd0, 8'd0, 1'b0, 7'd0}},
    '{'{MODE_SPAWN, 8'd255, 6'd0, 16'd0}, 1'b1,
      '{1'b1, ST_OK, 6'd0, 16'd1, 8'd255, 1'b0, 7'd1}},
    '{'{MODE_SPAWN, 8'd1, 6'd0, 16'd0}, 1'b1,
      '{1'b1, ST_OK, 6'd1, 16'd2, 8'd1, 1'b0, 7'd2}},
    '{'{MODE_SPAWN, 8'd128, 6'd63, 16'd65535}, 1'b1,
      '{1'b1, ST_OK, 6'd2, 16'd3, 8'd128, 1'b0, 7'd3}},
    '{'{MODE_FIND, 8'd0, 6'd0, 16'd2}, 1'b1,
      '{1'b1, ST_OK, 6'd1, 16'd2, 8'd1, 1'b0, 7'd3}},
    '{'{MODE_MARK, 8'd0, 6'd1, 16'd0}, 1'b1,
      '{1'b1, ST_OK, 6'd1, 16'd2, 8'd1, 1'b1, 7'd3}},
    '{'{MODE_INSPECT, 8'd0, 6'd1, 16'd0}, 1'b1,
      '{1'b1, ST_OK, 6'd1, 16'd2, 8'd1, 1'b1, 7'd3}},
    '{'{MODE_FREE, 8'd0, 6'd1, 16'd0}, 1'b1,
      '{1'b1, ST_OK, 6'd1, 16'd0, 8'd0, 1'b0, 7'd2}},
    '{'{MODE_FIND, 8'd0, 6'd0, 16'd2}, 1'b1,
      '{1'b0, ST_NOT_FOUND, 6'd0, 16'd0, 8'd0, 1'b0, 7'd2}},
    '{'{MODE_FREE, 8'd0, 6'd1, 16'd0}, 1'b1,
      '{1'b0, ST_SLOT_FREE, 6'd1, 16'd0, 8'd0, 1'b0, 7'd2}},
    '{'{MODE_SPAWN, 8'd9, 6'd40, 16'd7}, 1'b1,
      '{1'b1, ST_OK, 6'd1, 16'd4, 8'd9, 1'b0, 7'd3}},
    '{'{MODE_FIND, 8'd0, 6'd0, 16'd4}, 1'b0, '0},
    '{'{MODE_MARK, 8'd0, 6'd0, 16'd0}, 1'b0, '0}
  };

  phase_t phases [6] = '{
    '{150, 64, 0, 0, 60, 15, 1'b0},
    '{120, 127, 49, 0, 50, 15, 1'b0},
    '{100, 0, 0, 49, 10, 35, 1'b1},
    '{120, 5, 32, 32, 40, 30, 1'b0},
    '{60, 1, 49, 49, 45, 30, 1'b0},
    '{60, 64, 0, 0, 30, 40, 1'b0}
  };

  initial begin
    phase_t ph;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_kind[i]   = '0;
      tbl_handle[i] = '0;
      tbl_mark[i]   = 1'b0;
    end
    live_n     = 0;
    handle_ctr = 1;
    limit_reg  = 64;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) push_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);

    foreach (phases[p]) begin
      ph = phases[p];
      drain();
      write_limit(7'(ph.lim));
      tx_idle_pct  = ph.tx;
      rx_stall_pct = ph.rx;
      if (ph.hold) rx_hold_req = 1;
      for (int n = 0; n < ph.items; n++) push_op(gen_op(ph.spawn, ph.frees), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sth_pkg.sv
hw/rtl/sth_ram.sv
hw/rtl/sth_scan.sv
hw/rtl/slot_table_with_unique_handles_top.sv
verif/tb.sv
